// File: design/rns_modulus_lift_top_macros.svh
// ----------------------------------------------------------------------------
// rns_modulus_lift_top_macros.svh
// Assertion shorthands for the lift block checker.
// ----------------------------------------------------------------------------
`ifndef RNS_MODULUS_LIFT_TOP_MACROS_SVH
`define RNS_MODULUS_LIFT_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RML_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RML_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rml_pkg.sv
// ----------------------------------------------------------------------------
// rml_pkg
// Widths and register indexes shared by the lift block and its checker.
// ----------------------------------------------------------------------------
package rml_pkg;

	localparam int TDATA_W = 64;   // stream data width on both sides
	localparam int RES_W   = 61;   // residue and modulus width
	localparam int TB_W    = 7;    // t_bits register width
	localparam int APB_AW  = 5;    // byte address, registers at 8*i
	localparam int APB_DW  = 64;

	localparam logic [1:0] REG_T_BITS    = 2'd0;
	localparam logic [1:0] REG_PRIME     = 2'd1;
	localparam logic [1:0] REG_QUOTIENT  = 2'd2;
	localparam logic [1:0] REG_REMAINDER = 2'd3;

	localparam logic [TB_W-1:0]  T_BITS_RST = 7'd32;
	localparam logic [RES_W-1:0] PRIME_RST  = 61'd2;
	localparam logic [TB_W-1:0]  SHIFT_MIN  = 7'd2;
	localparam logic [TB_W-1:0]  SHIFT_MAX  = 7'd64;

endpackage

// File: design/rns_modulus_lift_top.sv
// ----------------------------------------------------------------------------
// rns_modulus_lift_top
// Lifts plaintext coefficients modulo 2^t_bits to residues modulo one RNS
// prime: (x*quotient_residue + ((remainder_of_q*x + t/2) >> t_bits)) mod q.
// ----------------------------------------------------------------------------
//  channel   dir  beat payload
//  s_*       in   tdata[63:0] coeff, tlast last
//  m_*       out  tdata[60:0] residue (63:61 zero), tlast last_res
//  apb       in   regs at 0x00 t_bits, 0x08 prime, 0x10 quotient, 0x18 rem
//
//  One beat in and one beat out per cycle while the output side is ready.
//  The pipeline has five arithmetic stages and then a 127-stage restoring
//  reduction, one remainder bit per stage, which sets the depth. Reset
//  loads the register defaults and empties the pipeline. While an output
//  beat waits, the whole pipeline holds; an empty first stage still takes
//  a new beat.
// ----------------------------------------------------------------------------
module rns_modulus_lift_top
	import rml_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [63:0] coeff
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [60:0] residue, [63:61] zero
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int P1_W  = 125;          // x * quotient_residue
	localparam int P2_W  = 128;          // remainder_of_q * x + t/2
	localparam int V_W   = 126;          // after the shift by at least two
	localparam int W_W   = 127;          // value to be reduced
	localparam int RED_N = W_W;          // one reduction stage per bit

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	logic [TB_W-1:0]    t_bits_q;
	logic [RES_W-1:0]   prime_q;
	logic [RES_W-1:0]   quot_q;
	logic [TDATA_W-1:0] rem_q;
	logic               cfg_wr;
	logic [1:0]         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:3];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_bits_q <= T_BITS_RST;
			prime_q  <= PRIME_RST;
			quot_q   <= '0;
			rem_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_T_BITS:    t_bits_q <= pwdata[TB_W-1:0];
				REG_PRIME:     prime_q  <= pwdata[RES_W-1:0];
				REG_QUOTIENT:  quot_q   <= pwdata[RES_W-1:0];
				REG_REMAINDER: rem_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_T_BITS:    prdata = {{(APB_DW-TB_W){1'b0}}, t_bits_q};
			REG_PRIME:     prdata = {{(APB_DW-RES_W){1'b0}}, prime_q};
			REG_QUOTIENT:  prdata = {{(APB_DW-RES_W){1'b0}}, quot_q};
			REG_REMAINDER: prdata = rem_q;
			default:       prdata = '0;
		endcase
	end

	// clamp the shift to the usable range of t_bits
	logic [TB_W-1:0]    shamt;
	logic [TDATA_W-1:0] half;

	always_comb begin
		if (t_bits_q < SHIFT_MIN)
			shamt = SHIFT_MIN;
		else if (t_bits_q > SHIFT_MAX)
			shamt = SHIFT_MAX;
		else
			shamt = t_bits_q;
		half = TDATA_W'(1) << (shamt - TB_W'(1));
	end

	function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
		return {32'd0, a} * {32'd0, b};
	endfunction

	function automatic logic [RES_W-1:0] mod_step(
		input logic [RES_W-1:0] r,
		input logic             b,
		input logic [RES_W-1:0] m
	);
		logic [RES_W:0]   t;
		logic [RES_W+1:0] d;
		t = {r, b};
		d = {1'b0, t} - {2'b00, m};
		return d[RES_W+1] ? t[RES_W-1:0] : d[RES_W-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// flow control: hold everything while the output beat waits
	// ------------------------------------------------------------------------
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic l_s1, l_s2, l_s3, l_s4, l_s5;
	logic ld_s1;

	assign en       = ~m_tvalid | m_tready;
	assign ld_s1    = en | ~v_s1;
	assign s_tready = ld_s1;

	// ------------------------------------------------------------------------
	// stage 1: 32x32 partial products
	// ------------------------------------------------------------------------
	logic [63:0] pq00_s1, pq10_s1, pr00_s1, pr01_s1, pr10_s1, pr11_s1;
	logic [60:0] pq01_s1, pq11_s1;
	logic [31:0] x_lo, x_hi, qr_lo, rq_lo, rq_hi;
	logic [28:0] qr_hi;

	assign x_lo  = s_tdata[31:0];
	assign x_hi  = s_tdata[63:32];
	assign qr_lo = quot_q[31:0];
	assign qr_hi = quot_q[60:32];
	assign rq_lo = rem_q[31:0];
	assign rq_hi = rem_q[63:32];

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			pq00_s1 <= mul32(x_lo, qr_lo);
			pq01_s1 <= 61'(mul32(x_lo, {3'b000, qr_hi}));
			pq10_s1 <= mul32(x_hi, qr_lo);
			pq11_s1 <= 61'(mul32(x_hi, {3'b000, qr_hi}));
			pr00_s1 <= mul32(rq_lo, x_lo);
			pr01_s1 <= mul32(rq_lo, x_hi);
			pr10_s1 <= mul32(rq_hi, x_lo);
			pr11_s1 <= mul32(rq_hi, x_hi);
			l_s1    <= s_tlast;
		end
	end

	// ------------------------------------------------------------------------
	// stage 2: middle sums, rounding half
	// stage 3: full products
	// stage 4: shift by t_bits
	// stage 5: add the two terms
	// ------------------------------------------------------------------------
	logic [P1_W-1:0] p1a_s2, p1_s3, p1_s4;
	logic [64:0]     p1m_s2, p2m_s2;
	logic [P2_W-1:0] p2a_s2, p2_s3;
	logic [V_W-1:0]  v_sh_s4;
	logic [W_W-1:0]  w_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			p1a_s2  <= {pq11_s1, pq00_s1};
			p1m_s2  <= {4'd0, pq01_s1} + {1'b0, pq10_s1};
			p2a_s2  <= {pr11_s1, pr00_s1} + {64'd0, half};
			p2m_s2  <= {1'b0, pr01_s1} + {1'b0, pr10_s1};
			l_s2    <= l_s1;

			p1_s3   <= p1a_s2 + (P1_W'(p1m_s2) << 32);
			p2_s3   <= p2a_s2 + (P2_W'(p2m_s2) << 32);
			l_s3    <= l_s2;

			v_sh_s4 <= V_W'(p2_s3 >> shamt);
			p1_s4   <= p1_s3;
			l_s4    <= l_s3;

			w_s5    <= W_W'(p1_s4) + W_W'(v_sh_s4);
			l_s5    <= l_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld_s1)
				v_s1 <= s_tvalid;
			if (en) begin
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
			end
		end
	end

	// ------------------------------------------------------------------------
	// restoring reduction modulo q, top bit first, one bit per stage
	// ------------------------------------------------------------------------
	logic [W_W-1:0]   red_w_s   [RED_N];
	logic [RES_W-1:0] red_rem_s [RED_N];
	logic             red_v_s   [RED_N];
	logic             red_l_s   [RED_N];

	for (genvar k = 0; k < RED_N; k++) begin : g_red
		logic [W_W-1:0]   w_in;
		logic [RES_W-1:0] rem_in;
		logic             v_in;
		logic             l_in;
		logic [RES_W-1:0] rem_nxt;

		if (k == 0) begin : g_first
			assign w_in   = w_s5;
			assign rem_in = '0;
			assign v_in   = v_s5;
			assign l_in   = l_s5;
		end else begin : g_next
			assign w_in   = red_w_s[k-1];
			assign rem_in = red_rem_s[k-1];
			assign v_in   = red_v_s[k-1];
			assign l_in   = red_l_s[k-1];
		end

		if (k == RED_N-1) begin : g_last
			// a zero modulus gives zero
			assign rem_nxt = (prime_q == '0) ? '0 : mod_step(rem_in, w_in[0], prime_q);
		end else begin : g_mid
			assign rem_nxt = mod_step(rem_in, w_in[W_W-1-k], prime_q);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				red_w_s[k]   <= w_in;
				red_rem_s[k] <= rem_nxt;
				red_l_s[k]   <= l_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				red_v_s[k] <= 1'b0;
			else if (en)
				red_v_s[k] <= v_in;
		end
	end

	assign m_tvalid = red_v_s[RED_N-1];
	assign m_tdata  = {{(TDATA_W-RES_W){1'b0}}, red_rem_s[RED_N-1]};
	assign m_tlast  = red_l_s[RED_N-1];

endmodule

// File: design/rml_checker.sv
// ----------------------------------------------------------------------------
// rml_checker
// Port-level checks on the lift block, bound to its top level.
// ----------------------------------------------------------------------------
`include "rns_modulus_lift_top_macros.svh"

module rml_checker
	import rml_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tready,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,   // [60:0] residue, [63:61] zero
	input  logic               m_tlast
);

	// a held output beat keeps its payload
	`RML_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")

	// the residue never spills into the padding bits
	`RML_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[TDATA_W-1:RES_W] == '0, "residue padding not zero")

	// with no result waiting the pipeline must be taking input
	`RML_ASSERT_SAME(a_no_block, !m_tvalid, s_tready, "input blocked with output empty")

	// a ready receiver lets the pipeline advance, so the input stays open
	`RML_ASSERT_SAME(a_ready_pass, m_tready, s_tready, "input blocked while output side ready")

endmodule

bind rns_modulus_lift_top rml_checker u_rml_checker (.*);
